@@ hdl/lelp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table package
// Shared types and constants of the LRU-evicting linear-probe table.
// ----------------------------------------------------------------------------
package lelp_pkg;

  localparam int KeyW  = 16;
  localparam int DataW = 32;
  localparam int TimeW = 32;
  localparam int CfgW  = 7;
  localparam int OccW  = 7;
  localparam int InW   = KeyW + DataW + TimeW;
  localparam int OutW  = 24;

  localparam logic OpLookup = 1'b0;
  localparam logic OpInsert = 1'b1;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StMod    = 9'b000000010,
    StLkRd   = 9'b000000100,
    StLkChk  = 9'b000001000,
    StScRd   = 9'b000010000,
    StScChk  = 9'b000100000,
    StEvict  = 9'b001000000,
    StProbe  = 9'b010000000,
    StFinish = 9'b100000000
  } state_e;

  typedef struct packed {
    logic start;
    logic mod_step;
    logic rd_en;
    logic addr_scan;
    logic adv;
    logic cnt_clr;
    logic cnt_inc;
    logic set_found;
    logic wr_stamp;
    logic sc_upd;
    logic evict;
    logic ins_write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_insert;
    logic mod_done;
    logic cnt_last;
    logic slot_empty;
    logic key_hit;
    logic idx_used;
    logic occ_over;
    logic out_busy;
  } sts_t;

endpackage

@@ hdl/lelp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table controller
// Sequences hashing, lookup probing, oldest-entry scan, eviction and insert.
// ----------------------------------------------------------------------------
module lelp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  lelp_pkg::sts_t  sts_i,
  output lelp_pkg::cmd_t  cmd_o
);

  lelp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lelp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = (state_q == lelp_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lelp_pkg::StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.start = 1'b1;
          state_d     = lelp_pkg::StMod;
        end
      end
      lelp_pkg::StMod: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          cmd_o.cnt_clr = 1'b1;
          if (!sts_i.op_insert) begin
            state_d = lelp_pkg::StLkRd;
          end else if (sts_i.occ_over) begin
            state_d = lelp_pkg::StScRd;
          end else begin
            state_d = lelp_pkg::StProbe;
          end
        end
      end
      lelp_pkg::StLkRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lelp_pkg::StLkChk;
      end
      lelp_pkg::StLkChk: begin
        if (sts_i.slot_empty) begin
          state_d = lelp_pkg::StFinish;
        end else if (sts_i.key_hit) begin
          cmd_o.set_found = 1'b1;
          cmd_o.wr_stamp  = 1'b1;
          state_d         = lelp_pkg::StFinish;
        end else if (sts_i.cnt_last) begin
          state_d = lelp_pkg::StFinish;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = lelp_pkg::StLkRd;
        end
      end
      lelp_pkg::StScRd: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.addr_scan = 1'b1;
        state_d         = lelp_pkg::StScChk;
      end
      lelp_pkg::StScChk: begin
        cmd_o.sc_upd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = lelp_pkg::StEvict;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = lelp_pkg::StScRd;
        end
      end
      lelp_pkg::StEvict: begin
        cmd_o.evict   = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        state_d       = lelp_pkg::StProbe;
      end
      lelp_pkg::StProbe: begin
        if (!sts_i.idx_used) begin
          cmd_o.ins_write = 1'b1;
          state_d         = lelp_pkg::StFinish;
        end else if (sts_i.cnt_last) begin
          state_d = lelp_pkg::StFinish;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      lelp_pkg::StFinish: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = lelp_pkg::StIdle;
        end
      end
      default: begin
        state_d = lelp_pkg::StIdle;
      end
    endcase
  end

endmodule

@@ hdl/lelp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table datapath
// Slot storage, serial hash remainder, probe counters and result register.
// ----------------------------------------------------------------------------
module lelp_dp #(
  parameter int SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lelp_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic [lelp_pkg::InW-1:0]     s_tdata_i,
  input  logic                         s_tuser_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [lelp_pkg::OutW-1:0]    m_tdata_o,
  input  lelp_pkg::cmd_t               cmd_i,
  output lelp_pkg::sts_t               sts_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = (IW + 1 > 8) ? IW + 1 : 8;

  logic [lelp_pkg::CfgW-1:0]  cfg_q;
  logic [NW-1:0]              n_s;
  logic [7:0]                 n8;
  logic [SLOTS-1:0]           used_q, tomb_q;
  logic [lelp_pkg::OccW-1:0]  occ_q;
  logic                       op_q;
  logic [lelp_pkg::KeyW-1:0]  key_q;
  logic [lelp_pkg::DataW-1:0] data_q;
  logic [lelp_pkg::TimeW-1:0] time_q;
  logic [3:0]                 bit_q;
  logic [6:0]                 rem_q, rem_nx;
  logic [7:0]                 rem_t;
  logic [IW-1:0]              idx_q, best_q, addr;
  logic [NW-1:0]              cnt_q, idx_inc;
  logic                       have_q, found_q, evicted_q, placed_q;
  logic [lelp_pkg::KeyW-1:0]  best_key_q, ekey_q, key_rd_q;
  logic [lelp_pkg::TimeW-1:0] best_stamp_q, stamp_rd_q;
  logic [7:0]                 occ1, occ2;
  logic                       m_valid_q;
  logic [lelp_pkg::OutW-1:0]  m_data_q;

  logic [lelp_pkg::KeyW-1:0]  key_mem   [SLOTS];
  logic [lelp_pkg::DataW-1:0] data_mem  [SLOTS];
  logic [lelp_pkg::TimeW-1:0] stamp_mem [SLOTS];

  always_comb begin
    if (cfg_q == '0) begin
      n_s = NW'(1);
    end else if (NW'(cfg_q) > NW'(SLOTS)) begin
      n_s = NW'(SLOTS);
    end else begin
      n_s = NW'(cfg_q);
    end
  end
  assign n8 = 8'(n_s);

  assign rem_t   = {rem_q, key_q[4'd15 - bit_q]};
  assign rem_nx  = (rem_t >= n8) ? 7'(rem_t - n8) : 7'(rem_t);
  assign idx_inc = NW'(idx_q) + NW'(1);
  assign addr    = cmd_i.addr_scan ? cnt_q[IW-1:0] : idx_q;

  assign occ1 = {1'b0, occ_q} + 8'd1 - {7'd0, evicted_q};
  assign occ2 = (!placed_q && occ1 != 8'd0) ? occ1 - 8'd1 : occ1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= lelp_pkg::CfgW'(64);
      used_q    <= '0;
      tomb_q    <= '0;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q  <= cfg_wdata_i;
        used_q <= '0;
        tomb_q <= '0;
        occ_q  <= '0;
      end else begin
        if (cmd_i.evict && have_q) begin
          used_q[best_q] <= 1'b0;
          tomb_q[best_q] <= 1'b1;
        end
        if (cmd_i.ins_write) begin
          used_q[idx_q] <= 1'b1;
          tomb_q[idx_q] <= 1'b0;
        end
        if (cmd_i.finish && op_q == lelp_pkg::OpInsert) begin
          occ_q <= occ2[lelp_pkg::OccW-1:0];
        end
      end
      if (cmd_i.finish) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= s_tuser_i;
      key_q     <= s_tdata_i[15:0];
      data_q    <= s_tdata_i[47:16];
      time_q    <= s_tdata_i[79:48];
      bit_q     <= '0;
      rem_q     <= '0;
      found_q   <= 1'b0;
      evicted_q <= 1'b0;
      placed_q  <= 1'b0;
      ekey_q    <= '0;
      have_q    <= 1'b0;
    end
    if (cmd_i.mod_step) begin
      bit_q <= bit_q + 4'd1;
      rem_q <= rem_nx;
      if (sts_o.mod_done) begin
        idx_q <= IW'(rem_nx);
      end
    end
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc || cmd_i.adv) begin
      cnt_q <= cnt_q + NW'(1);
    end
    if (cmd_i.adv) begin
      idx_q <= (idx_inc == n_s) ? '0 : IW'(idx_inc);
    end
    if (cmd_i.set_found) begin
      found_q <= 1'b1;
    end
    if (cmd_i.sc_upd && used_q[cnt_q[IW-1:0]] &&
        (!have_q || stamp_rd_q < best_stamp_q)) begin
      have_q       <= 1'b1;
      best_q       <= cnt_q[IW-1:0];
      best_stamp_q <= stamp_rd_q;
      best_key_q   <= key_rd_q;
    end
    if (cmd_i.evict && have_q) begin
      evicted_q <= 1'b1;
      ekey_q    <= best_key_q;
    end
    if (cmd_i.ins_write) begin
      placed_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      m_data_q <= {6'd0, ekey_q, evicted_q, found_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      key_rd_q   <= key_mem[addr];
      stamp_rd_q <= stamp_mem[addr];
    end
    if (cmd_i.ins_write) begin
      key_mem[idx_q]   <= key_q;
      data_mem[idx_q]  <= data_q;
      stamp_mem[idx_q] <= time_q;
    end else if (cmd_i.wr_stamp && time_q != '0) begin
      stamp_mem[idx_q] <= time_q;
    end
  end

  assign sts_o.op_insert  = (op_q == lelp_pkg::OpInsert);
  assign sts_o.mod_done   = (bit_q == 4'd15);
  assign sts_o.cnt_last   = (NW'(cnt_q + NW'(1)) == n_s);
  assign sts_o.slot_empty = !used_q[idx_q] && !tomb_q[idx_q];
  assign sts_o.key_hit    = used_q[idx_q] && (key_rd_q == key_q);
  assign sts_o.idx_used   = used_q[idx_q];
  assign sts_o.occ_over   = (({1'b0, occ_q} + 8'd1) > n8);
  assign sts_o.out_busy   = m_valid_q && !m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

@@ hdl/lru_evicting_linear_probe_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU-evicting linear-probe hash table
// Open-addressed key table with timestamp refresh and oldest-entry eviction.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. The home slot comes from a bit-serial
// remainder unit. A lookup then probes slot by slot, with a read state and a
// check state per probed slot because the key memory read is registered, and
// probes at most n slots for n active slots. An insert into a full table first
// scans all n slots for the oldest stamp, reading and checking each one, then
// probes the valid bits slot by slot. Writing the slot count empties the table
// at once.
module lru_evicting_linear_probe_table_core #(
  parameter int SLOTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lelp_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // key[15:0], data[47:16], time_req[79:48]
  input  logic [lelp_pkg::InW-1:0]   s_axis_tdata_i,
  // opcode
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // found[0], evicted[1], evicted_key[17:2], zero padding[23:18]
  output logic [lelp_pkg::OutW-1:0]  m_axis_tdata_o
);

  lelp_pkg::cmd_t cmd;
  lelp_pkg::sts_t sts;

  lelp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lelp_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ hdl/lelp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table checker
// Port-level checks of the input and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module lelp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [lelp_pkg::OutW-1:0]  m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result transaction changed.");

  a_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("Result reports both a hit and an eviction.");

  a_ekey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> m_axis_tdata_o[17:2] == '0)
    else $error("Evicted key is nonzero without an eviction.");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("New transaction accepted while one is in progress.");

endmodule

bind lru_evicting_linear_probe_table_core lelp_checker u_lelp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table testbench
// Drives lookups and inserts into the LRU-evicting linear-probe table under
// several slot counts and random stalls on both streams, and checks every result
// against a cycle-free model of the table in the bench, or an outcome fixed in the test row.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Slots = 64;

  typedef struct packed {
    logic [15:0] evicted_key;
    logic        evicted;
    logic        found;
  } outcome_t;

  typedef struct {
    bit          is_cfg;
    logic [6:0]  cfg;
    logic        op;
    logic [15:0] key;
    logic [31:0] data;
    logic [31:0] stamp;
    bit          typed;
    outcome_t    want;
  } row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [lelp_pkg::CfgW-1:0]   cfg_wdata_i = '0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [lelp_pkg::InW-1:0]    s_axis_tdata_i = '0;
  logic                        s_axis_tuser_i = 1'b0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [lelp_pkg::OutW-1:0]   m_axis_tdata_o;

  lru_evicting_linear_probe_table_core #(.SLOTS(Slots)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  // Table shadow.
  bit          live_q[Slots];
  bit          grave_q[Slots];
  logic [15:0] tag_q[Slots];
  logic [31:0] word_q[Slots];
  logic [31:0] age_q[Slots];
  int          live_count;
  logic [6:0]  slot_reg;

  outcome_t    pending_q[$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] clock_now = 32'd1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void wipe_table();
    for (int i = 0; i < Slots; i++) begin
      live_q[i] = 0;
      grave_q[i] = 0;
    end
    live_count = 0;
  endfunction

  function automatic outcome_t table_access(logic op, logic [15:0] key,
                                            logic [31:0] data, logic [31:0] t);
    outcome_t r;
    int n;
    int idx;
    int i;
    int best;
    bit have;
    r = '0;
    n = (slot_reg < 1) ? 1 : (slot_reg > Slots) ? Slots : slot_reg;
    idx = key % n;
    if (op == lelp_pkg::OpLookup) begin
      for (i = 0; i < n; i++) begin
        if (!live_q[idx] && !grave_q[idx]) break;
        if (live_q[idx] && tag_q[idx] == key) begin
          r.found = 1'b1;
          if (t != 0) age_q[idx] = t;
          break;
        end
        idx = (idx + 1) % n;
      end
    end else begin
      live_count++;
      if (live_count > n) begin
        have = 0;
        best = 0;
        for (i = 0; i < n; i++) begin
          if (live_q[i] && (!have || age_q[i] < age_q[best])) begin
            best = i;
            have = 1;
          end
        end
        if (have) begin
          live_q[best] = 0;
          grave_q[best] = 1;
          r.evicted = 1'b1;
          r.evicted_key = tag_q[best];
          live_count--;
        end
      end
      for (i = 0; i < n; i++) begin
        if (!live_q[idx]) break;
        idx = (idx + 1) % n;
      end
      if (i < n) begin
        live_q[idx] = 1;
        grave_q[idx] = 0;
        tag_q[idx] = key;
        word_q[idx] = data;
        age_q[idx] = t;
      end else if (live_count > 0) begin
        live_count--;
      end
      live_count &= 8'h7F;
    end
    return r;
  endfunction

  task automatic write_slot_count(logic [6:0] v);
    s_axis_tvalid_i <= 1'b0;
    wait (pending_q.size() == 0 && !s_axis_tvalid_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slot_reg = v;
    wipe_table();
  endtask

  task automatic send_op(logic op, logic [15:0] key, logic [31:0] data,
                         logic [31:0] t, bit typed, outcome_t want);
    outcome_t r;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {t, data, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = table_access(op, key, data, t);
    pending_q.push_back(typed ? want : r);
  endtask

  task automatic release_bus();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[17:0];
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got.found !== exp_r.found) begin
          $error("found: expected %0d, actual %0d", exp_r.found, got.found);
          err_cnt++;
        end
        if (got.evicted !== exp_r.evicted) begin
          $error("evicted: expected %0d, actual %0d", exp_r.evicted, got.evicted);
          err_cnt++;
        end
        if (got.evicted_key !== exp_r.evicted_key) begin
          $error("evicted_key: expected %h, actual %h",
                 exp_r.evicted_key, got.evicted_key);
          err_cnt++;
        end
      end
    end
  end

  function automatic row_t op_row(logic op, logic [15:0] key, logic [31:0] data,
                                  logic [31:0] t);
    row_t w;
    w = '{default: '0};
    w.op = op;
    w.key = key;
    w.data = data;
    w.stamp = t;
    return w;
  endfunction

  function automatic row_t cfg_row(logic [6:0] v);
    row_t w;
    w = '{default: '0};
    w.is_cfg = 1;
    w.cfg = v;
    return w;
  endfunction

  function automatic row_t typed_row(logic op, logic [15:0] key, logic [31:0] t,
                                     outcome_t want);
    row_t w;
    w = op_row(op, key, 32'h0, t);
    w.typed = 1;
    w.want = want;
    return w;
  endfunction

  initial begin
    row_t        plan[$];
    logic [6:0]  cfg_pick[10];
    logic [6:0]  v;
    logic        op;
    logic [15:0] key;
    logic [31:0] t;
    int          n;
    int          roll;

    slot_reg = 7'd64;
    wipe_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset, both key extremes.
    plan.push_back(typed_row(lelp_pkg::OpLookup, 16'hFFFF, 32'h1, '0));
    plan.push_back(typed_row(lelp_pkg::OpLookup, 16'h0000, 32'h0, '0));
    plan.push_back(cfg_row(7'd2));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd0, 32'h7FFFFFFF, 32'd5));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd2, 32'h80000000, 32'd3));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd4, 32'hFFFFFFFF, 32'd9));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd2, 32'h0, 32'd0));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd4, 32'h0, 32'd0));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd0, 32'h0, 32'hFFFFFFFF));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'hFFFF, 32'h0, 32'hFFFFFFFF));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd7, 32'h1, 32'h0));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'hFFFF, 32'h0, 32'd1));
    // Zero slot count acts as one slot.
    plan.push_back(cfg_row(7'd0));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd10, 32'h55, 32'd4));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd11, 32'h66, 32'd4));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd10, 32'h0, 32'd0));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd11, 32'h0, 32'd0));
    // Oversized count saturates; equal stamps evict the lowest slot.
    plan.push_back(cfg_row(7'd127));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd64, 32'h1, 32'd8));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd1, 32'h2, 32'd8));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd0, 32'h0, 32'd0));
    plan.push_back(op_row(lelp_pkg::OpLookup, 16'd64, 32'h0, 32'd2));
    plan.push_back(cfg_row(7'd3));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd3, 32'h1, 32'd8));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd6, 32'h2, 32'd8));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd9, 32'h3, 32'd8));
    plan.push_back(op_row(lelp_pkg::OpInsert, 16'd12, 32'h4, 32'd8));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_slot_count(plan[i].cfg);
      end else begin
        send_op(plan[i].op, plan[i].key, plan[i].data, plan[i].stamp,
                plan[i].typed, plan[i].want);
      end
    end
    release_bus();

    cfg_pick = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd17, 7'd64, 7'd127, 7'd0, 7'd33};
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 38 : 0;
      for (int c = 0; c < 4; c++) begin
        v = ($urandom_range(3, 0) == 0) ? 7'($urandom_range(127, 0))
                                        : cfg_pick[$urandom_range(9, 0)];
        if (phase == 0 && c == 0) v = 7'd64;
        if (phase == 1 && c == 0) v = 7'd1;
        write_slot_count(v);
        n = (v < 1) ? 1 : (v > Slots) ? Slots : v;
        for (int k = 0; k < 145; k++) begin
          op = ($urandom_range(99, 0) < 55) ? lelp_pkg::OpInsert : lelp_pkg::OpLookup;
          key = ($urandom_range(9, 0) < 7) ? 16'($urandom_range(2 * n + 3, 0))
                                           : 16'($urandom);
          clock_now += $urandom_range(3, 1);
          roll = $urandom_range(19, 0);
          t = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFFFFFF :
              (roll < 4) ? $urandom : clock_now;
          send_op(op, key, $urandom, t, 0, '0);
        end
        release_bus();
      end
    end

    wait (pending_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
